@@ rtl/longest_increasing_subsequence_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the longest increasing subsequence block
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LONGEST_INCREASING_SUBSEQUENCE_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LIS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// next-cycle implication
`define LIS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define LIS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LIS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/lis_pkg.sv @@
// ---------------------------------------------------------------------------
// lis_pkg
// Token operation codes shared by the cell chain, and fixed port widths of the top block.
// ---------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned ElemW = 32;  // element port width
  localparam int unsigned LenW  = 7;   // length port width

  // operation carried by a forward token
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SCAN   = 2'd1,
    OP_EMIT   = 2'd2
  } lis_op_t;

endpackage

@@ rtl/lis_cell.sv @@
// ---------------------------------------------------------------------------
// lis_cell
// One store entry: value, chain length, predecessor and trace rank. Forward
// tokens insert, scan and emit; backward tokens walk the predecessor links.
// ---------------------------------------------------------------------------
module lis_cell
  import lis_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned IDX        = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic [DATA_WIDTH+2*$clog2(MAX_ITEMS+1)+$clog2(MAX_ITEMS)+2:0] fwd_in,
  output logic [DATA_WIDTH+2*$clog2(MAX_ITEMS+1)+$clog2(MAX_ITEMS)+2:0] fwd_out,
  input  logic [$clog2(MAX_ITEMS+1)+$clog2(MAX_ITEMS)+1:0] bwd_in,
  output logic [$clog2(MAX_ITEMS+1)+$clog2(MAX_ITEMS)+1:0] bwd_out
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam logic [CW-1:0] MyPos = CW'(IDX);
  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  typedef struct packed {
    logic                         vld;
    lis_op_t                      op;
    logic [CW-1:0]                tgt;
    logic signed [DATA_WIDTH-1:0] val;
    logic [CW-1:0]                len;
    logic [IW-1:0]                idx;
  } fwd_tok_t;

  typedef struct packed {
    logic          vld;
    logic          act;
    logic [IW-1:0] tgt;
    logic [CW-1:0] rank;
  } bwd_tok_t;

  fwd_tok_t fi, fo, fo_next;
  bwd_tok_t bi, bo, bo_next;

  logic signed [DATA_WIDTH-1:0] val;
  logic [CW-1:0]                len;
  logic [IW-1:0]                pred;
  logic [CW-1:0]                rank;

  logic hit_back;

  assign fi      = fwd_tok_t'(fwd_in);
  assign bi      = bwd_tok_t'(bwd_in);
  assign fwd_out = fo;
  assign bwd_out = bo;

  // forward token update
  always_comb begin
    fo_next = fi;
    unique case (fi.op)
      OP_INSERT: begin
        if (MyPos < fi.tgt && val < fi.val && len >= fi.len) begin
          fo_next.len = len + CW'(1);
          fo_next.idx = MyIdx;
        end
      end
      OP_SCAN: begin
        if (MyPos < fi.tgt && len > fi.len) begin
          fo_next.len = len;
          fo_next.idx = MyIdx;
        end
      end
      OP_EMIT: begin
        if (rank == fi.len) begin
          fo_next.val = val;
        end
      end
      default: fo_next = fi;
    endcase
  end

  // backward token: follow the predecessor link when this entry is on the path
  assign hit_back = bi.act && (bi.tgt == MyIdx);

  always_comb begin
    bo_next = bi;
    if (hit_back) begin
      bo_next.tgt  = pred;
      bo_next.act  = (len > CW'(1));
      bo_next.rank = bi.rank - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fo.vld <= 1'b0;
      bo.vld <= 1'b0;
    end else begin
      fo.vld <= fo_next.vld;
      bo.vld <= bo_next.vld;
    end
    fo.op  <= fo_next.op;
    fo.tgt <= fo_next.tgt;
    fo.val <= fo_next.val;
    fo.len <= fo_next.len;
    fo.idx <= fo_next.idx;
    bo.act  <= bo_next.act;
    bo.tgt  <= bo_next.tgt;
    bo.rank <= bo_next.rank;
    // capture the new value at this entry's position
    if (fi.vld && fi.op == OP_INSERT && fi.tgt == MyPos) begin
      val  <= fi.val;
      len  <= fi.len;
      pred <= fi.idx;
    end
    // every trace sweep rewrites all ranks
    if (bi.vld) begin
      rank <= hit_back ? bi.rank : '0;
    end
  end

endmodule

@@ rtl/longest_increasing_subsequence.sv @@
// ---------------------------------------------------------------------------
// longest_increasing_subsequence
// Longest strictly increasing subsequence over a loaded sequence, computed
// by a chain of compare cells.
// ---------------------------------------------------------------------------
// Usage: pulse start with value (and last_item on the final element) while
// busy is low; each such edge is one transfer. While a sequence loads, the
// block takes one value every clock and busy stays low. Values beyond
// MAX_ITEMS are dropped and flagged on overflow. The transfer carrying
// last_item raises busy; the block then scans the chain for the first
// entry of maximum chain length, walks the predecessor links back through
// the chain and streams the subsequence out in ascending order, one
// result per clock. Each result is shown for one cycle with result_valid
// high and cannot be held off by the receiver; final_res marks the last
// one, and busy falls in that same cycle, so the next sequence may start
// right away.
// ---------------------------------------------------------------------------
`include "longest_increasing_subsequence_defines.svh"

module longest_increasing_subsequence
  import lis_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [ElemW-1:0] value,
  input  logic                    last_item,
  output logic                    result_valid,
  output logic signed [ElemW-1:0] element,
  output logic [LenW-1:0]         length,
  output logic                    final_res,
  output logic                    overflow
);

  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IW  = $clog2(MAX_ITEMS);
  localparam int unsigned FTW = DATA_WIDTH + 2 * CW + IW + 3;
  localparam int unsigned BTW = CW + IW + 2;

  typedef struct packed {
    logic                         vld;
    lis_op_t                      op;
    logic [CW-1:0]                tgt;
    logic signed [DATA_WIDTH-1:0] val;
    logic [CW-1:0]                len;
    logic [IW-1:0]                idx;
  } fwd_tok_t;

  typedef struct packed {
    logic          vld;
    logic          act;
    logic [IW-1:0] tgt;
    logic [CW-1:0] rank;
  } bwd_tok_t;

  typedef enum logic [4:0] {
    S_LOAD       = 5'b00001,
    S_SCAN_ISSUE = 5'b00010,
    S_SCAN_WAIT  = 5'b00100,
    S_TRACE      = 5'b01000,
    S_EMIT       = 5'b10000
  } state_t;

  state_t   state;
  fwd_tok_t inj;        // token entering the head of the chain
  bwd_tok_t binj;       // trace token entering the tail
  fwd_tok_t tail;
  bwd_tok_t bexit;
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] total;
  logic [CW-1:0] k;
  logic          issuing;

  logic signed [DATA_WIDTH-1:0] value_ext;

  logic [FTW-1:0] fwd_chain [0:MAX_ITEMS];
  logic [BTW-1:0] bwd_chain [0:MAX_ITEMS];

  assign value_ext = DATA_WIDTH'(value);
  assign busy      = (state != S_LOAD);

  assign fwd_chain[0]         = inj;
  assign bwd_chain[MAX_ITEMS] = binj;
  assign tail                 = fwd_tok_t'(fwd_chain[MAX_ITEMS]);
  assign bexit                = bwd_tok_t'(bwd_chain[0]);

  // Row of compare cells: forward tokens move head to tail, trace tokens
  // move tail to head, one cell per clock.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    lis_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_ITEMS  (MAX_ITEMS),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .fwd_in  (fwd_chain[i]),
      .fwd_out (fwd_chain[i+1]),
      .bwd_in  (bwd_chain[i+1]),
      .bwd_out (bwd_chain[i])
    );
  end

  // Sequencer: load, scan for the best end, trace back, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      ovf          <= 1'b0;
      issuing      <= 1'b0;
      inj.vld      <= 1'b0;
      binj.vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          binj.vld     <= 1'b0;
          result_valid <= 1'b0;
          inj.vld      <= start && (count < CW'(MAX_ITEMS));
          if (start) begin
            // store while there is room, otherwise drop and flag
            if (count < CW'(MAX_ITEMS)) begin
              inj.op  <= OP_INSERT;
              inj.tgt <= count;
              inj.val <= value_ext;
              inj.len <= CW'(1);
              inj.idx <= '0;
              count   <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (last_item) begin
              state <= S_SCAN_ISSUE;
            end
          end
        end
        S_SCAN_ISSUE: begin
          // follow the last insert one cell behind
          binj.vld     <= 1'b0;
          result_valid <= 1'b0;
          inj.vld      <= 1'b1;
          inj.op       <= OP_SCAN;
          inj.tgt      <= count;
          inj.len      <= '0;
          inj.idx      <= '0;
          state        <= S_SCAN_WAIT;
        end
        S_SCAN_WAIT: begin
          inj.vld      <= 1'b0;
          result_valid <= 1'b0;
          binj.vld     <= tail.vld && tail.op == OP_SCAN;
          if (tail.vld && tail.op == OP_SCAN) begin
            total     <= tail.len;
            binj.act  <= 1'b1;
            binj.tgt  <= tail.idx;
            binj.rank <= tail.len;
            state     <= S_TRACE;
          end
        end
        S_TRACE: begin
          inj.vld      <= 1'b0;
          binj.vld     <= 1'b0;
          result_valid <= 1'b0;
          if (bexit.vld) begin
            k       <= CW'(1);
            issuing <= 1'b1;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          binj.vld     <= 1'b0;
          inj.vld      <= issuing;
          result_valid <= tail.vld && tail.op == OP_EMIT;
          // one emit token per rank, back to back
          if (issuing) begin
            inj.op  <= OP_EMIT;
            inj.tgt <= count;
            inj.len <= k;
            inj.idx <= '0;
            if (k == total) begin
              issuing <= 1'b0;
            end else begin
              k <= k + CW'(1);
            end
          end
          if (tail.vld && tail.op == OP_EMIT) begin
            element      <= ElemW'($unsigned(tail.val));
            length       <= LenW'(total);
            final_res    <= (tail.len == total);
            overflow     <= ovf;
            if (tail.len == total) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end
          end
        end
        default: begin
          inj.vld      <= 1'b0;
          binj.vld     <= 1'b0;
          result_valid <= 1'b0;
          state        <= S_LOAD;
        end
      endcase
    end
  end

  `LIS_ASSERT_NXT(a_final_ends_burst, clk, rst, result_valid && final_res, !result_valid)
  `LIS_ASSERT_IMP(a_busy_during_burst, clk, rst, result_valid && !final_res, busy)
  `LIS_ASSERT_IMP(a_busy_after_last, clk, rst, $rose(busy), $past(start && last_item))
  `LIS_ASSERT_IMP(a_emit_only_in_emit, clk, rst, tail.vld && tail.op == OP_EMIT, state == S_EMIT)

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives sequences of signed values into the longest increasing subsequence
// block and checks every emitted element, length, end mark and overflow flag
// against a cycle-free model of the quadratic chain-length recurrence kept
// alongside it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lis_pkg::ElemW;
  import lis_pkg::LenW;

  localparam int unsigned MaxItems   = 64;
  localparam int unsigned DrainWait  = 400;      // covers scan, trace and stream
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandItems  = 320;
  localparam int unsigned CalmItems  = 80;       // tail of the run with no gaps

  localparam logic signed [ElemW-1:0] ValMin = {1'b1, {(ElemW-1){1'b0}}};
  localparam logic signed [ElemW-1:0] ValMax = {1'b0, {(ElemW-1){1'b1}}};

  typedef struct packed {
    logic signed [ElemW-1:0] elem;
    logic [LenW-1:0]         len;
    logic                    last;
    logic                    ovf;
  } subseq_elem_t;

  typedef logic signed [ElemW-1:0] seq_q_t[$];

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic signed [ElemW-1:0] value = '0;
  logic                    last_item = 1'b0;
  logic                    busy;
  logic                    result_valid;
  logic signed [ElemW-1:0] element;
  logic [LenW-1:0]         length;
  logic                    final_res;
  logic                    overflow;

  // model state: stored values, chain length and back link per entry
  logic signed [ElemW-1:0] seq_vals[MaxItems];
  int unsigned             run_len[MaxItems];
  int unsigned             back_link[MaxItems];
  int unsigned             seq_count = 0;
  bit                      dropped = 1'b0;

  subseq_elem_t expected_subseq[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  bit           gaps_on = 1'b1;    // cleared for the calm tail of the run
  bit           gappy_seq = 1'b0;  // per-sequence choice of bursty sending

  longest_increasing_subsequence dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .last_item    (last_item),
    .result_valid (result_valid),
    .element      (element),
    .length       (length),
    .final_res    (final_res),
    .overflow     (overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Update the model with one accepted value; on the last value of a
  // sequence, trace the subsequence back and queue it in ascending order.
  function automatic void track_value(logic signed [ElemW-1:0] v, logic lst);
    int unsigned             best;
    int unsigned             from;
    int unsigned             tail;
    int unsigned             n;
    int unsigned             idx;
    logic signed [ElemW-1:0] chain[MaxItems];
    subseq_elem_t            r;

    if (seq_count < MaxItems) begin
      best = 1;
      from = 0;
      for (int j = 0; j < seq_count; j++) begin
        if (seq_vals[j] < v && run_len[j] + 1 > best) begin
          best = run_len[j] + 1;
          from = j;
        end
      end
      seq_vals[seq_count]  = v;
      run_len[seq_count]   = best;
      back_link[seq_count] = from;
      seq_count++;
    end else begin
      dropped = 1'b1;
    end

    if (lst) begin
      if (seq_count > 0) begin
        tail = 0;
        for (int j = 1; j < seq_count; j++)
          if (run_len[j] > run_len[tail]) tail = j;
        n = run_len[tail];
        idx = tail;
        for (int k = n; k > 0; k--) begin
          chain[k-1] = seq_vals[idx];
          if (run_len[idx] > 1) idx = back_link[idx];
        end
        for (int k = 0; k < n; k++) begin
          r.elem = chain[k];
          r.len  = LenW'(n);
          r.last = (k + 1 == n);
          r.ovf  = dropped;
          expected_subseq.push_back(r);
        end
      end
      seq_count = 0;
      dropped = 1'b0;
    end
  endfunction

  // Results cannot be held off: check each one on the edge that ends it.
  always @(posedge clk) begin
    subseq_elem_t exp_r;
    if (!rst && result_valid) begin
      if (expected_subseq.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual element %0d",
                 $time, element);
        error_count++;
      end else begin
        exp_r = expected_subseq.pop_front();
        if (element !== exp_r.elem) begin
          $display("%0t: element mismatch: expected %0d, actual %0d",
                   $time, exp_r.elem, element);
          error_count++;
        end
        if (length !== exp_r.len) begin
          $display("%0t: length mismatch: expected %0d, actual %0d",
                   $time, exp_r.len, length);
          error_count++;
        end
        if (final_res !== exp_r.last) begin
          $display("%0t: final_res mismatch: expected %0b, actual %0b",
                   $time, exp_r.last, final_res);
          error_count++;
        end
        if (overflow !== exp_r.ovf) begin
          $display("%0t: overflow mismatch: expected %0b, actual %0b",
                   $time, exp_r.ovf, overflow);
          error_count++;
        end
      end
    end
  end

  // Hold start until the block takes the transfer, then update the model.
  task automatic send_item(input logic signed [ElemW-1:0] v, input logic lst);
    start     <= 1'b1;
    value     <= v;
    last_item <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_value(v, lst);
  endtask

  task automatic sender_gap();
    if (gaps_on && gappy_seq && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_seq(input seq_q_t vals);
    gappy_seq = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < vals.size(); i++) begin
      sender_gap();
      send_item(vals[i], i == vals.size() - 1);
    end
  endtask

  // Stop sending until every queued result has been checked.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_subseq.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_seq('{ValMin});
    send_seq('{ValMax});
    send_seq('{0});
    send_seq('{ValMin, -1, 0, 1, ValMax});
    send_seq('{ValMax, 0, ValMin});
  endtask

  task automatic test_ties_and_equal();
    // predecessor tie: 4 follows the earlier 3, not the later 1
    send_seq('{3, 1, 4});
    // end tie: first index of maximum length wins
    send_seq('{2, 1});
    // equal values never extend a chain
    send_seq('{4, 4, 4});
    send_seq('{-7, 5, -7, 5, 6});
  endtask

  task automatic test_capacity();
    seq_q_t vals;
    drain();
    // exactly full, strictly increasing: longest possible output
    for (int i = 0; i < MaxItems; i++)
      vals.push_back(ElemW'(i * 1000 - 30000 + $urandom_range(0, 999)));
    send_seq(vals);
    // two past full: the marked item itself is dropped
    vals.delete();
    for (int i = 0; i < MaxItems + 2; i++) vals.push_back($urandom);
    send_seq(vals);
    drain();
  endtask

  function automatic logic signed [ElemW-1:0] pick_value(int mode, int i, int base);
    case (mode)
      0: return $urandom;
      1: return ElemW'($signed($urandom_range(0, 20)) - 10);
      2: return ElemW'(base + i * 3 + $signed($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 5))
          0: return ValMin;
          1: return ValMax;
          2: return -1;
          3: return 0;
          4: return 1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic test_random();
    seq_q_t      vals;
    int unsigned sent;
    int unsigned n;
    int unsigned seq_idx;
    int          mode;
    int          base;

    sent = 0;
    seq_idx = 0;
    while (sent < RandItems) begin
      if ($urandom_range(0, 19) == 0) n = $urandom_range(50, 70);
      else n = $urandom_range(1, 12);
      if (n > RandItems - sent) n = RandItems - sent;
      mode = $urandom_range(0, 3);
      base = $signed($urandom_range(0, 2000)) - 1000;
      vals.delete();
      for (int i = 0; i < n; i++) vals.push_back(pick_value(mode, i, base));
      gaps_on = (sent + CalmItems < RandItems);
      send_seq(vals);
      sent += n;
      seq_idx++;
      if (seq_idx == 12) drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_ties_and_equal();
    test_capacity();
    test_random();

    drain();
    repeat (DrainWait) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
